// ----- hdl/ate_pkg.sv -----
// ----------------------------------------------------------------------------
// ate_pkg: shared types and constants for the accelerometer tilt estimator
// Holds field widths, the CORDIC arctangent table, the sequencer states and
// the queue entry that runs from the front end to the back end.
// ----------------------------------------------------------------------------
package ate_pkg;

  localparam int CORDIC_STEPS = 16;   // iterations per atan2, 8 to 24
  localparam int ATAN_LEN     = 24;
  localparam int STEP_W       = $clog2(ATAN_LEN);
  localparam int ACC_W        = 16;   // raw acceleration, Q4.11
  localparam int FILT_W       = 24;   // filtered acceleration, Q4.19
  localparam int CX_W         = 28;   // CORDIC x and y datapath
  localparam int CZ_W         = 21;   // CORDIC angle, Q.16
  localparam int ANG_W        = 16;   // angle, Q3.12
  localparam int RATE_W       = 17;
  localparam int KEEP_W       = 15;
  localparam int ORI_W        = 2;
  localparam logic signed [CZ_W-1:0] PI_Q16 = CZ_W'(205887);

  localparam logic [0:0] REG_FILTER_KEEP = 1'b0;
  localparam logic [0:0] REG_SCREEN_ORI  = 1'b1;

  localparam logic [ORI_W-1:0] ORI_PORTRAIT   = 2'd0;
  localparam logic [ORI_W-1:0] ORI_UPSIDEDOWN = 2'd1;
  localparam logic [ORI_W-1:0] ORI_LAND_RIGHT = 2'd2;
  localparam logic [ORI_W-1:0] ORI_LAND_LEFT  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_PSTART,
    ST_PWAIT,
    ST_RSTART,
    ST_RWAIT,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] ax;
    logic signed [ACC_W-1:0] ay;
    logic signed [ACC_W-1:0] az;
    logic                    calibrate;
    logic                    first;
  } sample_t;

  // round(atan(2^-i) * 65536)
  function automatic logic signed [CZ_W-1:0] atan_tab(input logic [STEP_W-1:0] idx);
    logic signed [CZ_W-1:0] v;
    case (idx)
      5'd0:    v = CZ_W'(51472);
      5'd1:    v = CZ_W'(30386);
      5'd2:    v = CZ_W'(16055);
      5'd3:    v = CZ_W'(8150);
      5'd4:    v = CZ_W'(4091);
      5'd5:    v = CZ_W'(2047);
      5'd6:    v = CZ_W'(1024);
      5'd7:    v = CZ_W'(512);
      5'd8:    v = CZ_W'(256);
      5'd9:    v = CZ_W'(128);
      5'd10:   v = CZ_W'(64);
      5'd11:   v = CZ_W'(32);
      5'd12:   v = CZ_W'(16);
      5'd13:   v = CZ_W'(8);
      5'd14:   v = CZ_W'(4);
      5'd15:   v = CZ_W'(2);
      5'd16:   v = CZ_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [ACC_W-1:0] neg_sat(input logic signed [ACC_W-1:0] v);
    return (v == {1'b1, {(ACC_W-1){1'b0}}}) ? {1'b0, {(ACC_W-1){1'b1}}} : -v;
  endfunction

endpackage

// ----- hdl/ate_front.sv -----
// ----------------------------------------------------------------------------
// ate_front: input acceptance and sample queue
// Accepts requests, tags the first sample after reset and holds up to two
// samples for the back end.
// ----------------------------------------------------------------------------
module ate_front import ate_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic        in_tuser,
  output logic        q_valid,
  input  logic        q_pop,
  output sample_t     q_item
);

  sample_t    mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       first_r, first_nxt;
  logic       push, pop;
  sample_t    item_in;

  assign in_tready = (count_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (count_r != 2'd0);
  assign pop       = q_pop && q_valid;
  assign q_item    = mem_r[rd_ptr_r];

  always_comb begin
    item_in.ax        = in_tdata[15:0];
    item_in.ay        = in_tdata[31:16];
    item_in.az        = in_tdata[47:32];
    item_in.calibrate = in_tuser;
    item_in.first     = first_r;
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
    first_nxt  = push ? 1'b0 : first_r;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
      first_r  <= 1'b1;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
      first_r  <= first_nxt;
    end
  end

endmodule

// ----- hdl/ate_cordic.sv -----
// ----------------------------------------------------------------------------
// ate_cordic: iterative vectoring CORDIC atan2
// One rotation per cycle; returns atan2(y, x) in Q3.12 radians.
// ----------------------------------------------------------------------------
module ate_cordic import ate_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [FILT_W:0]   y_in,
  input  logic signed [FILT_W:0]   x_in,
  output logic                     done,
  output logic signed [ANG_W-1:0]  angle
);

  logic signed [CX_W-1:0]  x_r, x_nxt, y_r, y_nxt;
  logic signed [CZ_W-1:0]  z_r, z_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic                    busy_r, busy_nxt, done_r, done_nxt;
  logic signed [ANG_W-1:0] res_r, res_nxt;
  logic signed [CX_W-1:0]  xs, ys, dx, dy;
  logic signed [CZ_W-1:0]  zr;

  assign done  = done_r;
  assign angle = res_r;

  always_comb begin
    xs = CX_W'(x_in);
    ys = CX_W'(y_in);
    dx = y_r >>> step_r;
    dy = x_r >>> step_r;
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r;
    step_nxt = step_r; busy_nxt = busy_r; done_nxt = 1'b0; res_nxt = res_r;
    zr = '0;
    if (start) begin
      step_nxt = '0;
      if (x_in == '0 && y_in == '0) begin
        res_nxt  = '0;
        done_nxt = 1'b1;
        busy_nxt = 1'b0;
      end else begin
        busy_nxt = 1'b1;
        if (x_in < 0) begin
          z_nxt = (y_in >= 0) ? PI_Q16 : -PI_Q16;
          x_nxt = -xs;
          y_nxt = -ys;
        end else begin
          z_nxt = '0;
          x_nxt = xs;
          y_nxt = ys;
        end
      end
    end else if (busy_r) begin
      if (y_r < 0) begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - atan_tab(step_r);
      end else begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + atan_tab(step_r);
      end
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(CORDIC_STEPS - 1)) begin
        zr       = (z_nxt + CZ_W'(8)) >>> 4;
        res_nxt  = zr[ANG_W-1:0];
        done_nxt = 1'b1;
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

endmodule

// ----- hdl/accel_tilt_estimator.sv -----
// ----------------------------------------------------------------------------
// accel_tilt_estimator: accelerometer tilt with per-axis IIR low-pass
// Filters each sample, finds pitch and roll by CORDIC atan2, centres them,
// forms rates and remaps all but accel_z by the screen orientation.
// ----------------------------------------------------------------------------
// From input request to result: the two-entry queue, the filter (one shared
// 24x18 multiplier, two products per axis; skipped for the first sample),
// the two atan2 runs on one CORDIC unit and a finishing step. The back end
// works on one sample at a time and takes the next only once the result
// register is free; the queue can hold further requests meanwhile.
// Synchronous active-low reset clears the filter, centres, last angles and
// marks the next sample as first; registers return to their reset values.
module accel_tilt_estimator import ate_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // accel_x, accel_y, accel_z
  input  logic         in_tuser,   // calibrate
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata,  // tilt_x, tilt_z, rate_x, rate_z,
                                   // out_accel_x, out_accel_y, out_accel_z, zero pad
  input  logic         cfg_we,
  input  logic [0:0]   cfg_addr,
  input  logic [14:0]  cfg_wdata
);

  // Configuration registers.
  logic [KEEP_W-1:0] keep_r;
  logic [ORI_W-1:0]  ori_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_r <= KEEP_W'(27853);
      ori_r  <= ORI_PORTRAIT;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_FILTER_KEEP: keep_r <= cfg_wdata;
        default:         ori_r  <= cfg_wdata[ORI_W-1:0];
      endcase
    end
  end

  // Front end: accepts requests into a two-entry queue.
  logic    q_valid, q_pop;
  sample_t q_item;

  ate_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .q_valid, .q_pop, .q_item
  );

  // Back end sequencer.
  seq_state_t state_r, state_nxt;
  logic [1:0] axis_r;
  logic       cor_start, cor_done;
  logic signed [FILT_W:0]  cor_y, cor_x;
  logic signed [ANG_W-1:0] cor_angle;

  logic signed [FILT_W-1:0] filt_r [3];
  logic signed [41:0]       acc_r;
  logic signed [ANG_W-1:0]  pitch_r, roll_raw_r;
  logic signed [ANG_W-1:0]  cp_r, cr_r;
  logic signed [RATE_W-1:0] lp_r, lr_r;
  logic                     out_valid_r;
  logic [119:0]             out_data_r;

  logic out_free;
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (q_valid) state_nxt = q_item.first ? ST_PSTART : ST_MUL_A;
      ST_MUL_A:  state_nxt = ST_MUL_B;
      ST_MUL_B:  state_nxt = (axis_r == 2'd2) ? ST_PSTART : ST_MUL_A;
      ST_PSTART: state_nxt = ST_PWAIT;
      ST_PWAIT:  if (cor_done) state_nxt = ST_RSTART;
      ST_RSTART: state_nxt = ST_RWAIT;
      ST_RWAIT:  if (cor_done) state_nxt = ST_DONE;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cor_start = 1'b0;
    q_pop     = 1'b0;
    unique case (state_r)
      ST_PSTART, ST_RSTART: cor_start = 1'b1;
      ST_DONE:              q_pop = out_free;
      default: ;
    endcase
  end

  // Filter arithmetic: one multiplier shared by both products of each axis.
  logic signed [ACC_W-1:0]  raw_sel;
  logic signed [FILT_W-1:0] scaled, f_sel;
  logic signed [23:0]       mul_a;
  logic signed [17:0]       mul_b;
  logic signed [41:0]       product, sum;
  logic [16:0]              w_new;

  always_comb begin
    case (axis_r)
      2'd0:    raw_sel = q_item.ax;
      2'd1:    raw_sel = q_item.ay;
      default: raw_sel = q_item.az;
    endcase
    case (axis_r)
      2'd0:    f_sel = filt_r[0];
      2'd1:    f_sel = filt_r[1];
      default: f_sel = filt_r[2];
    endcase
    scaled = {raw_sel, 8'd0};
    w_new  = 17'd32768 - 17'(keep_r);
    if (state_r == ST_MUL_A) begin
      mul_a = f_sel;
      mul_b = {3'd0, keep_r};
    end else begin
      mul_a = scaled;
      mul_b = {1'b0, w_new};
    end
    product = mul_a * mul_b;
    sum     = (acc_r + product + 42'sd16384) >>> 15;
  end

  // CORDIC operands: pitch = atan2(-fy, -fz), roll = -atan2(-fx, -fz).
  assign cor_x = -(FILT_W+1)'(filt_r[2]);
  assign cor_y = (state_r == ST_RSTART) ? -(FILT_W+1)'(filt_r[0])
                                        : -(FILT_W+1)'(filt_r[1]);

  ate_cordic u_cordic (
    .clk, .rst_n, .start(cor_start), .y_in(cor_y), .x_in(cor_x),
    .done(cor_done), .angle(cor_angle)
  );

  // Finishing step: centring, rates and orientation remap.
  logic signed [ANG_W-1:0]  roll, cp_use, cr_use;
  logic signed [RATE_W-1:0] pc, rc;
  logic signed [RATE_W:0]   rx, rz;
  logic signed [RATE_W-1:0] tx_w, tz_w, rx_o, rz_o;
  logic signed [ACC_W-1:0]  ax_o, ay_o;
  logic [119:0]             res_data;

  always_comb begin
    roll   = -roll_raw_r;
    cp_use = q_item.calibrate ? pitch_r : cp_r;
    cr_use = q_item.calibrate ? roll : cr_r;
    pc = RATE_W'(pitch_r) - RATE_W'(cp_use);
    rc = RATE_W'(roll) - RATE_W'(cr_use);
    rx = (RATE_W+1)'(lp_r) - (RATE_W+1)'(pc);
    rz = (RATE_W+1)'(lr_r) - (RATE_W+1)'(rc);
    case (ori_r)
      ORI_UPSIDEDOWN: begin
        tx_w = -pc; tz_w = -rc;
        rx_o = -rx[RATE_W-1:0]; rz_o = -rz[RATE_W-1:0];
        ax_o = neg_sat(q_item.ax); ay_o = neg_sat(q_item.ay);
      end
      ORI_LAND_RIGHT: begin
        tx_w = -rc; tz_w = pc;
        rx_o = -rz[RATE_W-1:0]; rz_o = rx[RATE_W-1:0];
        ax_o = neg_sat(q_item.ay); ay_o = q_item.ax;
      end
      ORI_LAND_LEFT: begin
        tx_w = rc; tz_w = -pc;
        rx_o = rz[RATE_W-1:0]; rz_o = -rx[RATE_W-1:0];
        ax_o = q_item.ay; ay_o = neg_sat(q_item.ax);
      end
      default: begin
        tx_w = pc; tz_w = rc;
        rx_o = rx[RATE_W-1:0]; rz_o = rz[RATE_W-1:0];
        ax_o = q_item.ax; ay_o = q_item.ay;
      end
    endcase
    res_data = {6'd0, q_item.az, ay_o, ax_o, rz_o, rx_o,
                tz_w[ANG_W-1:0], tx_w[ANG_W-1:0]};
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state_r == ST_MUL_A) begin
      acc_r <= product;
    end
    if (state_r == ST_PWAIT && cor_done) begin
      pitch_r <= cor_angle;
    end
    if (state_r == ST_RWAIT && cor_done) begin
      roll_raw_r <= cor_angle;
    end
    if (state_r == ST_DONE && out_free) begin
      out_data_r <= res_data;
    end
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      axis_r      <= 2'd0;
      out_valid_r <= 1'b0;
      filt_r[0]   <= '0;
      filt_r[1]   <= '0;
      filt_r[2]   <= '0;
      cp_r        <= '0;
      cr_r        <= '0;
      lp_r        <= '0;
      lr_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE && q_valid) begin
        axis_r <= 2'd0;
        if (q_item.first) begin
          filt_r[0] <= {q_item.ax, 8'd0};
          filt_r[1] <= {q_item.ay, 8'd0};
          filt_r[2] <= {q_item.az, 8'd0};
        end
      end
      if (state_r == ST_MUL_B) begin
        case (axis_r)
          2'd0:    filt_r[0] <= sum[FILT_W-1:0];
          2'd1:    filt_r[1] <= sum[FILT_W-1:0];
          default: filt_r[2] <= sum[FILT_W-1:0];
        endcase
        axis_r <= axis_r + 2'd1;
      end
      if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
        cp_r <= cp_use;
        cr_r <= cr_use;
        lp_r <= pc;
        lr_r <= rc;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A result is loaded only from the finishing state.
  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(state_r == ST_DONE))
    else $error("result loaded outside finishing state");

  // The queue is popped only when the output register can take the result.
  a_pop_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_valid && (!out_valid_r || out_tready)))
    else $error("sample popped without room for its result");

  // The CORDIC reports completion only while the sequencer waits for it.
  a_cordic_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cor_done |-> (state_r == ST_PWAIT || state_r == ST_RWAIT))
    else $error("CORDIC completion outside a wait state");

endmodule

// ----- verif/accel_tilt_estimator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_tilt_estimator_tb: self-checking bench for the tilt estimator
// Drives acceleration requests with random idling on both channels, predicts
// every result with a bit-true model of the filter, the CORDIC and the remap,
// and compares each result field by field in request order.
// ----------------------------------------------------------------------------
module accel_tilt_estimator_tb;
  import ate_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 120;
  localparam int RANDOM_ITEMS   = 1430;

  // Fields from the highest bit down, so tilt_x sits in the lowest bits.
  typedef struct packed {
    logic signed [15:0] acc_z;
    logic signed [15:0] acc_y;
    logic signed [15:0] acc_x;
    logic signed [16:0] rate_z;
    logic signed [16:0] rate_x;
    logic signed [15:0] tilt_z;
    logic signed [15:0] tilt_x;
  } tilt_result_t;

  // One row of the directed table. When has_exp is set, the expected result
  // typed into the row is checked against the predictor as well.
  typedef struct {
    logic signed [15:0] ax, ay, az;
    logic               cal;
    bit                 has_exp;
    tilt_result_t       exp_res;
  } sample_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [47:0]  in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [119:0] out_tdata;
  logic         cfg_we = 1'b0;
  logic [0:0]   cfg_addr = REG_FILTER_KEEP;
  logic [14:0]  cfg_wdata = '0;

  accel_tilt_estimator dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state, a private copy of everything the block keeps.
  logic [14:0]        keep_frac;
  logic [1:0]         screen_ori;
  logic signed [23:0] filt_acc [3];
  bit                 first_pending;
  logic signed [15:0] ctr_pitch, ctr_roll;
  logic signed [16:0] prev_pitch, prev_roll;

  tilt_result_t pending_results [$];
  int           error_count = 0;
  int           idle_pct = 28;
  int           idle_cycles = 0;

  function automatic longint atan_step(int i);
    longint t [24] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                       256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};
    return t[i];
  endfunction

  // Vectoring CORDIC: atan2(y, x) in Q3.12 radians.
  function automatic longint vector_angle(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? 205887 : -205887;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y < 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    return (z + 8) >>> 4;
  endfunction

  function automatic logic signed [15:0] flip_sat(logic signed [15:0] v);
    return (v == -16'sd32768) ? 16'sd32767 : -v;
  endfunction

  function automatic tilt_result_t predict_tilt(logic signed [15:0] ax,
                                                logic signed [15:0] ay,
                                                logic signed [15:0] az,
                                                logic cal);
    longint raw [3];
    longint acc, pitch, roll, rx, rz, t;
    tilt_result_t r;
    raw[0] = ax; raw[1] = ay; raw[2] = az;
    for (int k = 0; k < 3; k++) begin
      if (first_pending) begin
        filt_acc[k] = 24'(raw[k] * 256);
      end else begin
        acc = longint'(filt_acc[k]) * longint'(keep_frac)
            + (32768 - longint'(keep_frac)) * raw[k] * 256 + 16384;
        filt_acc[k] = 24'(acc >>> 15);
      end
    end
    first_pending = 0;
    pitch = vector_angle(-longint'(filt_acc[1]), -longint'(filt_acc[2]));
    roll  = -vector_angle(-longint'(filt_acc[0]), -longint'(filt_acc[2]));
    if (cal) begin
      ctr_pitch = 16'(pitch);
      ctr_roll  = 16'(roll);
    end
    pitch -= ctr_pitch;
    roll  -= ctr_roll;
    rx = prev_pitch - pitch;
    rz = prev_roll - roll;
    prev_pitch = 17'(pitch);
    prev_roll  = 17'(roll);
    r.acc_z = az;
    case (screen_ori)
      ORI_UPSIDEDOWN: begin
        r.tilt_x = 16'(-pitch); r.tilt_z = 16'(-roll);
        r.rate_x = 17'(-rx); r.rate_z = 17'(-rz);
        r.acc_x = flip_sat(ax); r.acc_y = flip_sat(ay);
      end
      ORI_LAND_RIGHT: begin
        t = rx;
        r.tilt_x = 16'(-roll); r.tilt_z = 16'(pitch);
        r.rate_x = 17'(-rz); r.rate_z = 17'(t);
        r.acc_x = flip_sat(ay); r.acc_y = ax;
      end
      ORI_LAND_LEFT: begin
        t = rx;
        r.tilt_x = 16'(roll); r.tilt_z = 16'(-pitch);
        r.rate_x = 17'(rz); r.rate_z = 17'(-t);
        r.acc_x = ay; r.acc_y = flip_sat(ax);
      end
      default: begin
        r.tilt_x = 16'(pitch); r.tilt_z = 16'(roll);
        r.rate_x = 17'(rx); r.rate_z = 17'(rz);
        r.acc_x = ax; r.acc_y = ay;
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    error_count++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // Register writes happen only with the block idle, and the predictor
  // follows them at once.
  task automatic write_reg(logic [0:0] idx, logic [14:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    if (idx == REG_FILTER_KEEP) keep_frac = val;
    else screen_ori = val[1:0];
  endtask

  // Sender: hold one request until it is accepted, idling at random before it.
  task automatic send_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                             logic signed [15:0] az, logic cal);
    while ($urandom_range(99, 0) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {az, ay, ax};
    in_tuser  <= cal;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(predict_tilt(ax, ay, az, cal));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Receiver: random stalls on the result channel, and the result checks.
  always @(posedge clk) begin
    tilt_result_t got, want;
    if (rst_n) begin
      out_tready <= ($urandom_range(99, 0) >= idle_pct);
      if (out_tvalid && out_tready) begin
        got = out_tdata[113:0];
        if (out_tdata[119:114] != 0) report_mismatch("padding", out_tdata[119:114], 0);
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = pending_results.pop_front();
          if (got.tilt_x != want.tilt_x) report_mismatch("tilt_x", got.tilt_x, want.tilt_x);
          if (got.tilt_z != want.tilt_z) report_mismatch("tilt_z", got.tilt_z, want.tilt_z);
          if (got.rate_x != want.rate_x) report_mismatch("rate_x", got.rate_x, want.rate_x);
          if (got.rate_z != want.rate_z) report_mismatch("rate_z", got.rate_z, want.rate_z);
          if (got.acc_x != want.acc_x) report_mismatch("accel_x", got.acc_x, want.acc_x);
          if (got.acc_y != want.acc_y) report_mismatch("accel_y", got.acc_y, want.acc_y);
          if (got.acc_z != want.acc_z) report_mismatch("accel_z", got.acc_z, want.acc_z);
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a request.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // A portrait result from the given tilts, rates and accelerations.
  function automatic tilt_result_t plain_result(logic signed [15:0] tx,
                                                logic signed [15:0] tz,
                                                logic signed [16:0] rx,
                                                logic signed [16:0] rz,
                                                logic signed [15:0] ax,
                                                logic signed [15:0] ay,
                                                logic signed [15:0] az);
    tilt_result_t r;
    r = '{tilt_x: tx, tilt_z: tz, rate_x: rx, rate_z: rz,
          acc_x: ax, acc_y: ay, acc_z: az};
    return r;
  endfunction

  initial begin
    sample_row_t  rows [$];
    sample_row_t  row;
    tilt_result_t want;
    logic signed [15:0] bx, by, bz;
    int mode;

    keep_frac = 15'd27853; screen_ori = ORI_PORTRAIT;
    filt_acc = '{0, 0, 0}; first_pending = 1;
    ctr_pitch = 0; ctr_roll = 0; prev_pitch = 0; prev_roll = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. The first row is the zero vector straight after reset,
    // so every angle is zero. The second holds gravity straight down with a
    // calibrate, which must give zero tilt. The rest are extremes.
    rows.push_back('{0, 0, 0, 0, 1, plain_result(0, 0, 0, 0, 0, 0, 0)});
    rows.push_back('{0, 0, 2048, 1, 1, plain_result(0, 0, 0, 0, 0, 0, 2048)});
    rows.push_back('{-32768, -32768, -32768, 0, 0, '0});
    rows.push_back('{32767, 32767, 32767, 0, 0, '0});
    rows.push_back('{-32768, 32767, 0, 0, 0, '0});
    rows.push_back('{32767, -32768, 0, 1, 0, '0});
    rows.push_back('{0, 0, -2048, 0, 0, '0});
    rows.push_back('{-1, -1, -1, 0, 0, '0});
    rows.push_back('{16'h5555, 16'hAAAA, 16'h5555, 0, 0, '0});
    rows.push_back('{16'hAAAA, 16'h5555, 16'hAAAA, 1, 0, '0});
    foreach (rows[i]) begin
      row = rows[i];
      if (row.has_exp) begin
        // Peek at the predictor without disturbing it is not possible, so the
        // typed-in value is compared with what the predictor pushed.
        send_sample(row.ax, row.ay, row.az, row.cal);
        want = pending_results[$];
        if (want != row.exp_res) report_mismatch("directed row", i, 0);
      end else begin
        send_sample(row.ax, row.ay, row.az, row.cal);
      end
    end

    // Every orientation with negation of the most negative value, and the
    // extremes of the filter coefficient including keep zero.
    for (int ori = 0; ori < 4; ori++) begin
      wait_drained();
      write_reg(REG_SCREEN_ORI, 15'(ori));
      write_reg(REG_FILTER_KEEP, (ori == 0) ? 15'd0 : (ori == 1) ? 15'h7FFF : 15'(ori * 5000));
      send_sample(-16'sd32768, -16'sd32768, 16'sd1000, ori[0]);
      send_sample(16'sd300, -16'sd700, -16'sd32768, 1'b0);
      send_sample(16'sd32767, 16'sd0, 16'sd0, 1'b0);
    end

    // Random part: mostly slowly moving sensor data around a random rest
    // vector, some full-range noise, and new settings between phases.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 120 == 0) begin
        wait_drained();
        write_reg(REG_SCREEN_ORI, 15'($urandom_range(3, 0)));
        mode = $urandom_range(3, 0);
        write_reg(REG_FILTER_KEEP, (mode == 0) ? 15'd0 : (mode == 1) ? 15'h7FFF
                                   : 15'($urandom_range(32767, 0)));
        bx = 16'($urandom_range(4095, 0) - 2048);
        by = 16'($urandom_range(4095, 0) - 2048);
        bz = 16'($urandom_range(4095, 0) - 2048);
        // The long stretch with no idling on either side.
        idle_pct = (n >= 480 && n < 720) ? 0 : 28;
      end
      if ($urandom_range(99, 0) < 15)
        send_sample(16'($urandom), 16'($urandom), 16'($urandom),
                    1'($urandom_range(1, 0)));
      else
        send_sample(16'(bx + $signed(16'($urandom_range(400, 0))) - 200),
                    16'(by + $signed(16'($urandom_range(400, 0))) - 200),
                    16'(bz + $signed(16'($urandom_range(400, 0))) - 200),
                    $urandom_range(99, 0) < 5);
    end

    wait_drained();
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- accel_tilt_estimator.f -----
hdl/ate_pkg.sv
hdl/ate_front.sv
hdl/ate_cordic.sv
hdl/accel_tilt_estimator.sv
verif/accel_tilt_estimator_tb.sv
